FILE: src/cms_pkg.sv
`default_nettype none

package cms_pkg;

    // Field widths of the byte stream and of the emitted frames
    localparam int DATA_W    = 8;
    localparam int LEN_W     = 10;
    localparam int ID_W      = 11;
    localparam int DESC_W    = 16;
    localparam int PAYLOAD_W = 48;
    localparam int FLEN_W    = 4;
    localparam int SEQ_W     = 2;
    localparam int SLOT_W    = 3;
    localparam int COUNT_W   = 8;

    // Frame layout
    localparam int BYTES_PER_FRAME = 6;
    localparam int SEQ_SHIFT       = 12;
    localparam int COUNT_SHIFT     = 6;
    localparam int DESC_BYTES      = 2;

    // ceil(len / 6) = ((len + 5) * RECIP_6) >> RECIP_SHIFT, exact for len + 5 < 2048
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_6     = 2731;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BYTES_PER_FRAME - 1);

    // One frame as it leaves the segmenter
    typedef struct packed {
        logic                 last_frame;
        logic [FLEN_W-1:0]    frame_length;
        logic [PAYLOAD_W-1:0] payload;
        logic [DESC_W-1:0]    descriptor;
        logic [ID_W-1:0]      frame_id;
    } frame_t;

    // One message byte with its side information
    typedef struct packed {
        logic [ID_W-1:0]   can_id;
        logic [LEN_W-1:0]  msg_length;
        logic [DATA_W-1:0] data_byte;
    } byte_req_t;

endpackage

`default_nettype wire

FILE: src/can_message_segmenter.sv
// CAN message segmenter.
// Slave channel s_*: one message byte per request; s_tdata carries data_byte,
// msg_length and can_id. Master channel m_*: one classic CAN frame per
// request; m_tdata carries frame_id, descriptor, payload and frame_length,
// and m_tlast marks the final frame of a message.
// A frame goes out after every sixth byte of a message and after its final
// byte; a message longer than MAX_MSG_BYTES is swallowed without frames.
// A byte accepted into the input register is decoded there, and its frame,
// if any, is loaded into the result register that drives m_*.
// Throughput: one byte per cycle unless the receiver stalls. The byte
// decode, frame build and state update are one pass between the input
// register and the result register. When the receiver stalls, a waiting
// frame holds on m_* and the byte stage keeps going until it holds a byte
// that needs the result register; then s_tready drops until the frame is taken.
// Reset clears the sequence number, the message position and both valid
// flags; the block is ready for a byte as soon as reset ends.
`default_nettype none

module can_message_segmenter
    import cms_pkg::*;
#(
    parameter int MAX_MSG_BYTES = 512
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // data_byte[7:0], msg_length[17:8], can_id[28:18]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // frame_id[10:0], descriptor[26:11],
                                        // payload[74:27], frame_length[78:75]
    output logic             m_tlast
);

    localparam int REQ_W = $bits(byte_req_t);
    localparam int OUT_W = $bits(frame_t) - 1;

    logic      in_valid_reg, in_valid_next;
    byte_req_t in_req_reg;
    logic      fire;
    logic      emit;
    logic      out_free;
    frame_t    frame;
    frame_t    frame_out;

    // Step the byte when its frame, if any, has room
    assign fire     = in_valid_reg && (out_free || !emit);
    assign s_tready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_req_reg <= byte_req_t'(s_tdata[REQ_W-1:0]);
    end

    cms_framer #(
        .MAX_MSG_BYTES(MAX_MSG_BYTES)
    ) u_framer (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (in_req_reg),
        .emit  (emit),
        .frame (frame)
    );

    cms_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && emit),
        .frame_in  (frame),
        .free      (out_free),
        .valid     (m_tvalid),
        .taken     (m_tready),
        .frame_out (frame_out)
    );

    // Pack the frame without its last flag, pad to whole bytes
    assign m_tdata = {1'b0, frame_out[OUT_W-1:0]};
    assign m_tlast = frame_out.last_frame;

endmodule

`default_nettype wire

FILE: src/cms_framer.sv
`default_nettype none

module cms_framer
    import cms_pkg::*;
#(
    parameter int MAX_MSG_BYTES = 512
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,       // consume req this cycle
    input  wire byte_req_t req,
    output logic           emit,       // req closes a frame
    output frame_t         frame
);

    // Frame index never passes (MAX_MSG_BYTES - 1) / 6
    localparam int FI_W = $clog2((MAX_MSG_BYTES - 1) / BYTES_PER_FRAME + 2);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MSG_BYTES);
    localparam int CX_W = LEN_W + 1;
    localparam int PROD_W = CX_W + RECIP_SHIFT;

    logic [SEQ_W-1:0]     seq_reg, seq_next;
    logic [LEN_W-1:0]     byte_pos_reg, byte_pos_next;
    logic [FI_W-1:0]      frame_idx_reg, frame_idx_next;
    logic [PAYLOAD_W-1:0] buf_reg, buf_next;

    logic [LEN_W-1:0]     len_eff;
    logic [LEN_W-1:0]     pos;
    logic                 is_last;
    logic                 oversize;
    logic [LEN_W-1:0]     fi_x6;
    logic [LEN_W-1:0]     fill;
    logic [SLOT_W-1:0]    slot;
    logic [PAYLOAD_W-1:0] payload_or;
    logic [CX_W-1:0]      len_round;
    logic [PROD_W-1:0]    count_prod;
    logic [COUNT_W-1:0]   frame_count;

    // Decode the byte against the message state
    always_comb
    begin
        len_eff  = (req.msg_length == '0) ? LEN_W'(1) : req.msg_length;
        pos      = byte_pos_reg + LEN_W'(1);
        is_last  = (pos >= len_eff);
        oversize = (len_eff > MAX_LEN);
        fi_x6    = LEN_W'({frame_idx_reg, 2'b00}) + LEN_W'({frame_idx_reg, 1'b0});
        fill     = byte_pos_reg - fi_x6;
        slot     = (fill >= LEN_W'(BYTES_PER_FRAME)) ? LAST_SLOT : fill[SLOT_W-1:0];
        payload_or = buf_reg | (PAYLOAD_W'(req.data_byte) << {slot, 3'b000});
        emit     = !oversize && (slot == LAST_SLOT || is_last);
    end

    // Frame count by reciprocal multiply
    always_comb
    begin
        len_round   = CX_W'(len_eff) + CX_W'(BYTES_PER_FRAME - 1);
        count_prod  = PROD_W'(len_round) * PROD_W'(RECIP_6);
        frame_count = count_prod[RECIP_SHIFT +: COUNT_W];
    end

    // Build the outgoing frame
    always_comb
    begin
        frame.frame_id     = req.can_id;
        frame.descriptor   = (DESC_W'(seq_reg) << SEQ_SHIFT)
                           | (DESC_W'(frame_count) << COUNT_SHIFT)
                           | DESC_W'(frame_idx_reg);
        frame.payload      = payload_or;
        frame.frame_length = FLEN_W'(slot) + FLEN_W'(DESC_BYTES + 1);
        frame.last_frame   = is_last;
    end

    // Advance message state
    always_comb
    begin
        seq_next       = seq_reg;
        byte_pos_next  = byte_pos_reg;
        frame_idx_next = frame_idx_reg;
        buf_next       = buf_reg;
        if (fire)
        begin
            byte_pos_next = pos;
            if (oversize)
            begin
                if (is_last)
                begin
                    byte_pos_next  = '0;
                    frame_idx_next = '0;
                    buf_next       = '0;
                end
            end
            else
            begin
                buf_next = payload_or;
                if (emit && is_last)
                begin
                    seq_next       = seq_reg + SEQ_W'(1);
                    byte_pos_next  = '0;
                    frame_idx_next = '0;
                    buf_next       = '0;
                end
                else if (emit)
                begin
                    frame_idx_next = frame_idx_reg + FI_W'(1);
                    buf_next       = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= '0;
            byte_pos_reg  <= '0;
            frame_idx_reg <= '0;
            buf_reg       <= '0;
        end
        else
        begin
            seq_reg       <= seq_next;
            byte_pos_reg  <= byte_pos_next;
            frame_idx_reg <= frame_idx_next;
            buf_reg       <= buf_next;
        end
    end

    // Frames already cut never run ahead of the bytes consumed
    a_fill_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        fi_x6 <= byte_pos_reg)
        else $error("frame index ahead of byte position");

    // A closing frame restarts the message
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit && is_last |=> byte_pos_reg == '0 && frame_idx_reg == '0)
        else $error("message state not cleared after last frame");

    // Sequence moves only on the last frame of a sent message
    a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && emit && is_last) |=> $stable(seq_reg))
        else $error("sequence changed without a closing frame");

endmodule

`default_nettype wire

FILE: src/cms_out_reg.sv
`default_nettype none

module cms_out_reg
    import cms_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load,
    input  wire frame_t frame_in,
    output logic        free,       // may load this cycle
    output logic        valid,
    input  wire logic   taken,
    output frame_t      frame_out
);

    logic   valid_reg, valid_next;
    frame_t frame_reg;

    assign free      = !valid_reg || taken;
    assign valid     = valid_reg;
    assign frame_out = frame_reg;

    // Hold until taken, refill in the same cycle
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (taken)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            frame_reg <= frame_in;
    end

    // Never overwrite a waiting frame
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result register overwritten");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none

module tb_top
    import cms_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MSG_LIMIT      = 512;
    localparam int RAND_ITEMS     = 1830;
    localparam int MAX_WAIT       = 17;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tlast;

    // Byte requests waiting to be sent, frames waiting to be received
    byte_req_t   byte_queue[$];
    frame_t      frames_due[$];
    byte_req_t   byte_in_flight;
    int          src_wait;
    bit          src_burst;
    int          sink_wait;
    int          fail_count = 0;
    int          idle_cycles = 0;

    // Segmenter state as the testbench tracks it
    bit [1:0]    msg_seq;
    int unsigned msg_pos;
    int unsigned frame_num;
    bit [47:0]   frame_bytes;

    can_message_segmenter #(
        .MAX_MSG_BYTES(MSG_LIMIT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drop per-message state at the end of a message
    function automatic void end_message();
        msg_pos     = 0;
        frame_num   = 0;
        frame_bytes = '0;
    endfunction

    // Fold one accepted byte into the current frame; queue the frame it closes
    function automatic void segment_byte(input byte_req_t req);
        int unsigned len;
        int unsigned next_pos;
        int unsigned slot;
        int unsigned count;
        bit          closes_msg;
        frame_t      frame;

        len = req.msg_length;
        if (len == 0)
            len = 1;
        next_pos   = (msg_pos + 1) & 32'h3FF;
        closes_msg = next_pos >= len;

        // Oversized messages only advance the position and end the message on its last byte
        if (len > MSG_LIMIT)
        begin
            msg_pos = next_pos;
            if (closes_msg)
                end_message();
            return;
        end

        slot = msg_pos - frame_num * BYTES_PER_FRAME;
        if (slot >= BYTES_PER_FRAME)
            slot = BYTES_PER_FRAME - 1;
        frame_bytes |= 48'(req.data_byte) << (8 * slot);
        msg_pos = next_pos;

        if (slot != BYTES_PER_FRAME - 1 && !closes_msg)
            return;

        count = (len + BYTES_PER_FRAME - 1) / BYTES_PER_FRAME;
        frame.frame_id     = req.can_id;
        frame.descriptor   = 16'((32'(msg_seq) << SEQ_SHIFT) | (count << COUNT_SHIFT)
                                 | frame_num);
        frame.payload      = frame_bytes;
        frame.frame_length = 4'(slot + DESC_BYTES + 1);
        frame.last_frame   = closes_msg;
        frames_due.push_back(frame);

        if (closes_msg)
        begin
            msg_seq = msg_seq + 2'd1;
            end_message();
        end
        else
        begin
            frame_num   = (frame_num + 1) & 32'hFF;
            frame_bytes = '0;
        end
    endfunction

    function automatic void add_byte(input logic [7:0] data, input int len, input int id);
        byte_req_t req;

        req.data_byte  = data;
        req.msg_length = LEN_W'(len);
        req.can_id     = ID_W'(id);
        byte_queue.push_back(req);
    endfunction

    function automatic void add_message(input int n_bytes, input int len, input int id);
        for (int i = 0; i < n_bytes; i++)
            add_byte(8'($urandom_range(0, 255)), len, id);
    endfunction

    // Source side: present queued bytes, hold them until taken, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            src_wait  = 0;
            src_burst = 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                segment_byte(byte_in_flight);
            if (!(s_tvalid && !s_tready))
            begin
                if (src_wait > 0)
                begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (byte_queue.size() > 0)
                begin
                    byte_in_flight = byte_queue.pop_front();
                    s_tdata  <= 32'(byte_in_flight);
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 63) == 0)
                        src_burst = !src_burst;
                    src_wait = (src_burst || $urandom_range(0, 1) == 0) ? 0
                               : $urandom_range(0, MAX_WAIT);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: check each taken frame against the oldest expected one
    always @(posedge clk or negedge rst_n)
    begin
        frame_t got;
        frame_t want;

        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = frame_t'({m_tlast, m_tdata[78:0]});
                if (frames_due.size() == 0)
                begin
                    $error("unexpected frame: id %0h descriptor %0h", got.frame_id,
                           got.descriptor);
                    fail_count++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (got.frame_id !== want.frame_id)
                    begin
                        $error("frame_id: expected %0h, got %0h", want.frame_id,
                               got.frame_id);
                        fail_count++;
                    end
                    if (got.descriptor !== want.descriptor)
                    begin
                        $error("descriptor: expected %0h, got %0h", want.descriptor,
                               got.descriptor);
                        fail_count++;
                    end
                    if (got.payload !== want.payload)
                    begin
                        $error("payload: expected %0h, got %0h", want.payload, got.payload);
                        fail_count++;
                    end
                    if (got.frame_length !== want.frame_length)
                    begin
                        $error("frame_length: expected %0d, got %0d", want.frame_length,
                               got.frame_length);
                        fail_count++;
                    end
                    if (got.last_frame !== want.last_frame)
                    begin
                        $error("last_frame: expected %0b, got %0b", want.last_frame,
                               got.last_frame);
                        fail_count++;
                    end
                end
                sink_wait = ($urandom_range(0, 2) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
            end
            else if (sink_wait > 0)
            begin
                sink_wait--;
            end
            m_tready <= (sink_wait == 0);
        end
    end

    // Stop a hung run: count cycles in which neither side moves a request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int  id;
        int  len;
        int  k;
        int  pick;
        bit  did_full;
        bit  did_over;

        msg_seq  = '0;
        did_full = 1'b0;
        did_over = 1'b0;
        end_message();

        // Zero length and the smallest message, field extremes
        add_byte(8'hFF, 0, 11'h7FF);
        add_byte(8'h00, 1, 11'h000);
        // Length a multiple of six: one full frame
        for (int i = 0; i < 6; i++)
            add_byte((i % 2 == 0) ? 8'hFF : 8'h00, 6, 11'h555);
        // Seven bytes: a full frame and a one-byte last frame
        add_message(7, 7, 11'h2AA);
        // Length shrinks mid-message
        add_byte(8'h5A, 10, 11'h123);
        add_byte(8'hA5, 10, 11'h123);
        add_byte(8'h3C, 2, 11'h123);
        // Oversized bytes, then a short length closes the message
        add_byte(8'h11, 1023, 11'h456);
        add_byte(8'h22, 1023, 11'h456);
        add_byte(8'h33, 1, 11'h456);

        // Mostly well-formed messages with random content, some broken ones
        while (byte_queue.size() < RAND_ITEMS)
        begin
            id   = $urandom_range(0, 2047);
            pick = $urandom_range(0, 9);
            if (!did_full && byte_queue.size() > 300)
            begin
                add_message(MSG_LIMIT, MSG_LIMIT, id);
                did_full = 1'b1;
            end
            else if (!did_over && byte_queue.size() > 900)
            begin
                add_message(MSG_LIMIT + 1, MSG_LIMIT + 1, id);
                did_over = 1'b1;
            end
            else if (pick <= 5)
            begin
                len = ($urandom_range(0, 2) == 0) ? BYTES_PER_FRAME * $urandom_range(1, 5)
                      : $urandom_range(1, 30);
                add_message(len, len, id);
            end
            else if (pick == 6)
            begin
                add_message(1, 0, id);
            end
            else if (pick == 7)
            begin
                len = $urandom_range(31, 120);
                add_message(len, len, id);
            end
            else if (pick == 8)
            begin
                len = $urandom_range(5, 40);
                k   = $urandom_range(1, len - 1);
                add_message(k, len, id);
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, k + 1), id);
            end
            else
            begin
                k = $urandom_range(1, 20);
                for (int i = 0; i < k; i++)
                    add_byte(8'($urandom_range(0, 255)),
                             $urandom_range(0, 1) ? $urandom_range(MSG_LIMIT + 1, 1023)
                             : $urandom_range(30, MSG_LIMIT), id);
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, k + 1), id);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all bytes taken and all frames seen, then a quiet tail before the check
        while (byte_queue.size() > 0 || s_tvalid || frames_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (frames_due.size() != 0)
        begin
            $error("%0d frames never arrived", frames_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
